@@ rtl/kabf_pkg.sv @@
// Package for the two-state angle/bias Kalman filter core.
// Holds stream and configuration port widths, register indexes and reset values.
// No dependencies.
`default_nettype none

package kabf_pkg;

    // stream payload widths
    localparam int GYRO_W      = 32;
    localparam int ACCEL_W     = 32;
    localparam int STEP_W      = 21;
    localparam int IN_TDATA_W  = 88;   // 85 bits of fields padded to whole bytes
    localparam int OUT_FIELD_W = 32;
    localparam int OUT_TDATA_W = 64;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 28;
    localparam int QA_W       = 25;
    localparam int QB_W       = 25;
    localparam int RN_W       = 28;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t CFG_ANGLE_NOISE = 2'd0;
    localparam cfg_addr_t CFG_BIAS_NOISE  = 2'd1;
    localparam cfg_addr_t CFG_MEAS_NOISE  = 2'd2;

    localparam logic [QA_W-1:0] QA_RESET = 25'd16777;
    localparam logic [QB_W-1:0] QB_RESET = 25'd50332;
    localparam logic [RN_W-1:0] RN_RESET = 28'd503316;

endpackage

`default_nettype wire

@@ rtl/kalman_angle_bias_filter_core.sv @@
// Single-axis Kalman filter core: tilt angle plus gyro bias, 2x2 covariance.
// NCH = ceil(VALUE_WIDTH/16) 16-bit multiplier slices; the correction is skipped when S is not positive.
// One item in flight at a time: the shared 16-bit-slice multiplier and the
// one-bit-per-cycle divider serve every item, and a stalled sink holds the next one.
// Reset (rst_n low, asynchronous): angle and bias zero, diagonal covariance 1.0,
// noise registers at their documented defaults, output channel empty.
`default_nettype none

module kalman_angle_bias_filter_core #(
    parameter int FRAC_BITS   = 24,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire kabf_pkg::cfg_addr_t             cfg_addr,
    input  wire logic [kabf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: gyro_in[31:0], accel_angle_in[63:32], step_time[84:64], zero pad
    input  wire logic [kabf_pkg::IN_TDATA_W-1:0] s_tdata,
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tdata: angle_out[31:0], rate_out[63:32]
    output logic [kabf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // tuser: fault[0]
    output logic                                 m_tuser
);

    import kabf_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int XW    = ((W > 32) ? W : 32) + 4;      // headroom for sums
    localparam int NCH   = (W + 15) / 16;                // 16-bit multiplier slices
    localparam int MBW   = NCH * 16;
    localparam int AW    = W + MBW;                      // product accumulator
    localparam int DN    = W + FRAC_BITS;                // dividend bits / divide steps
    localparam int SMW   = W + MBW + FRAC_BITS;          // common magnitude width
    localparam int CNTW  = $clog2(DN + 1);

    localparam logic signed [XW-1:0] XMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] XMIN = ~XMAX;
    localparam logic [SMW-1:0]       LIM  = {{(SMW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    // ------------------------------------------------------------------
    // arithmetic helpers
    // ------------------------------------------------------------------
    function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] a);
        return {{(XW-W){a[W-1]}}, a};
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
        logic signed [W-1:0] r;
        if (x > XMAX)
            r = XMAX[W-1:0];
        else if (x < XMIN)
            r = XMIN[W-1:0];
        else
            r = x[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        logic [W-1:0] u;
        u = x;
        return x[W-1] ? (~u + 1'b1) : u;
    endfunction

    // signed result from sign and magnitude, clamped to the value range
    function automatic logic signed [W-1:0] mag_sat(input logic neg, input logic [SMW-1:0] m);
        logic signed [W-1:0] r;
        if (neg)
            r = (m >= LIM) ? XMIN[W-1:0] : (~m[W-1:0] + 1'b1);
        else
            r = (m >= LIM) ? XMAX[W-1:0] : m[W-1:0];
        return r;
    endfunction

    localparam logic signed [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
    localparam logic signed [W-1:0]  ONE_W = sat_w(ONE_X);

    // ------------------------------------------------------------------
    // sequencer types
    // ------------------------------------------------------------------
    typedef enum logic [3:0] {
        ST_IDLE, ST_RATE, ST_LOAD, ST_MUL, ST_MRES, ST_UPD,
        ST_CORR, ST_CHK, ST_DIV, ST_DFIN, ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        M_DT_RATE, M_DT_PBB, M_DT_SUM, M_QB_DT,
        M_K0_IN, M_K1_IN, M_K0_P00, M_K0_P01, M_K1_P00, M_K1_P01
    } mop_t;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    mop_t   mop_reg, mop_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    // filter state
    logic signed [W-1:0] ang_reg, ang_next, bias_reg, bias_next;
    logic signed [W-1:0] paa_reg, paa_next, pab_reg, pab_next;
    logic signed [W-1:0] pba_reg, pba_next, pbb_reg, pbb_next;

    // noise registers
    logic [QA_W-1:0] qa_reg, qa_next;
    logic [QB_W-1:0] qb_reg, qb_next;
    logic [RN_W-1:0] rn_reg, rn_next;

    // output channel
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_FIELD_W-1:0] out_angle_reg, out_angle_next;
    logic [OUT_FIELD_W-1:0] out_rate_reg, out_rate_next;
    logic                   out_fault_reg, out_fault_next;

    // working values of one item
    logic signed [W-1:0] gyro_reg, gyro_next, meas_reg, meas_next, dt_reg, dt_next;
    logic signed [W-1:0] rate_reg, rate_next, dp11_reg, dp11_next;
    logic signed [W-1:0] innov_reg, innov_next, s_reg, s_next;
    logic signed [W-1:0] k0_reg, k0_next, k1_reg, k1_next;
    logic signed [W-1:0] p00_reg, p00_next, p01_reg, p01_next;
    logic signed [W-1:0] prod_reg, prod_next;
    logic                fault_reg, fault_next;

    // shared multiplier
    logic [W-1:0]   ma_reg, ma_next;
    logic [MBW-1:0] mb_reg, mb_next;
    logic           neg_reg, neg_next;
    logic [AW-1:0]  acc_reg, acc_next;

    // two-lane divider sharing the divisor S
    logic [DN-1:0] dn0_reg, dn0_next, dn1_reg, dn1_next;
    logic [DN-1:0] q0_reg, q0_next, q1_reg, q1_next;
    logic [W-1:0]  rem0_reg, rem0_next, rem1_reg, rem1_next;
    logic [W-1:0]  d_reg, d_next;
    logic          dneg0_reg, dneg0_next, dneg1_reg, dneg1_next;

    // combinational helpers
    logic signed [W-1:0]  op_a, op_b, qa_w, qb_w, rn_w;
    logic signed [XW-1:0] ang_ext, rate_ext;
    logic [W+15:0]        pp;
    logic [W:0]           r20, r21;

    assign qa_w = sat_w(XW'(qa_reg));
    assign qb_w = sat_w(XW'(qb_reg));
    assign rn_w = sat_w(XW'(rn_reg));

    assign ang_ext  = sx(ang_reg);
    assign rate_ext = sx(rate_reg);

    assign pp  = ma_reg * mb_reg[MBW-1 -: 16];
    assign r20 = {rem0_reg, dn0_reg[DN-1]};
    assign r21 = {rem1_reg, dn1_reg[DN-1]};

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = dt_reg;
        op_b = rate_reg;
        case (mop_reg)
            M_DT_RATE: begin op_a = dt_reg; op_b = rate_reg; end
            M_DT_PBB:  begin op_a = dt_reg; op_b = pbb_reg;  end
            M_DT_SUM:
            begin
                op_a = dt_reg;
                op_b = sat_w(sx(dp11_reg) - sx(pab_reg) - sx(pba_reg) + sx(qa_w));
            end
            M_QB_DT:   begin op_a = qb_w;   op_b = dt_reg;   end
            M_K0_IN:   begin op_a = k0_reg; op_b = innov_reg; end
            M_K1_IN:   begin op_a = k1_reg; op_b = innov_reg; end
            M_K0_P00:  begin op_a = k0_reg; op_b = p00_reg;  end
            M_K0_P01:  begin op_a = k0_reg; op_b = p01_reg;  end
            M_K1_P00:  begin op_a = k1_reg; op_b = p00_reg;  end
            M_K1_P01:  begin op_a = k1_reg; op_b = p01_reg;  end
            default:   begin op_a = dt_reg; op_b = rate_reg; end
        endcase
    end

    // ------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        mop_next   = mop_reg;
        cnt_next   = cnt_reg;
        ang_next   = ang_reg;
        bias_next  = bias_reg;
        paa_next   = paa_reg;
        pab_next   = pab_reg;
        pba_next   = pba_reg;
        pbb_next   = pbb_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        rn_next    = rn_reg;
        out_valid_next = out_valid_reg;
        out_angle_next = out_angle_reg;
        out_rate_next  = out_rate_reg;
        out_fault_next = out_fault_reg;
        gyro_next  = gyro_reg;
        meas_next  = meas_reg;
        dt_next    = dt_reg;
        rate_next  = rate_reg;
        dp11_next  = dp11_reg;
        innov_next = innov_reg;
        s_next     = s_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        p00_next   = p00_reg;
        p01_next   = p01_reg;
        prod_next  = prod_reg;
        fault_next = fault_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        dn0_next   = dn0_reg;
        dn1_next   = dn1_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        rem0_next  = rem0_reg;
        rem1_next  = rem1_reg;
        d_next     = d_reg;
        dneg0_next = dneg0_reg;
        dneg1_next = dneg1_reg;

        // drop the held result once the sink takes it
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ANGLE_NOISE: qa_next = cfg_wdata[QA_W-1:0];
                CFG_BIAS_NOISE:  qb_next = cfg_wdata[QB_W-1:0];
                CFG_MEAS_NOISE:  rn_next = cfg_wdata[RN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    gyro_next  = sat_w({{(XW-GYRO_W){s_tdata[GYRO_W-1]}},
                                        s_tdata[GYRO_W-1:0]});
                    meas_next  = sat_w({{(XW-ACCEL_W){s_tdata[GYRO_W+ACCEL_W-1]}},
                                        s_tdata[GYRO_W+ACCEL_W-1:GYRO_W]});
                    dt_next    = sat_w(XW'(s_tdata[GYRO_W+ACCEL_W+STEP_W-1:GYRO_W+ACCEL_W]));
                    fault_next = 1'b0;
                    state_next = ST_RATE;
                end
            end

            ST_RATE:
            begin
                rate_next  = sat_w(sx(gyro_reg) - sx(bias_reg));
                mop_next   = M_DT_RATE;
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                ma_next    = mag(op_a);
                mb_next    = MBW'(mag(op_b));
                neg_next   = op_a[W-1] ^ op_b[W-1];
                acc_next   = '0;
                cnt_next   = CNTW'(NCH - 1);
                state_next = ST_MUL;
            end

            // one 16-bit slice of the multiplier operand per cycle, top slice first
            ST_MUL:
            begin
                acc_next = (acc_reg << 16) + AW'(pp);
                mb_next  = mb_reg << 16;
                if (cnt_reg == '0)
                    state_next = ST_MRES;
                else
                    cnt_next = cnt_reg - 1'b1;
            end

            ST_MRES:
            begin
                prod_next  = mag_sat(neg_reg, SMW'(acc_reg >> FRAC_BITS));
                state_next = ST_UPD;
            end

            ST_UPD:
            begin
                state_next = ST_LOAD;
                case (mop_reg)
                    M_DT_RATE:
                    begin
                        ang_next = sat_w(sx(ang_reg) + sx(prod_reg));
                        mop_next = M_DT_PBB;
                    end
                    M_DT_PBB:
                    begin
                        dp11_next = prod_reg;
                        mop_next  = M_DT_SUM;
                    end
                    M_DT_SUM:
                    begin
                        paa_next = sat_w(sx(paa_reg) + sx(prod_reg));
                        pab_next = sat_w(sx(pab_reg) - sx(dp11_reg));
                        pba_next = sat_w(sx(pba_reg) - sx(dp11_reg));
                        mop_next = M_QB_DT;
                    end
                    M_QB_DT:
                    begin
                        pbb_next   = sat_w(sx(pbb_reg) + sx(prod_reg));
                        state_next = ST_CORR;
                    end
                    M_K0_IN:
                    begin
                        ang_next = sat_w(sx(ang_reg) + sx(prod_reg));
                        mop_next = M_K1_IN;
                    end
                    M_K1_IN:
                    begin
                        bias_next = sat_w(sx(bias_reg) + sx(prod_reg));
                        mop_next  = M_K0_P00;
                    end
                    M_K0_P00:
                    begin
                        paa_next = sat_w(sx(paa_reg) - sx(prod_reg));
                        mop_next = M_K0_P01;
                    end
                    M_K0_P01:
                    begin
                        pab_next = sat_w(sx(pab_reg) - sx(prod_reg));
                        mop_next = M_K1_P00;
                    end
                    M_K1_P00:
                    begin
                        pba_next = sat_w(sx(pba_reg) - sx(prod_reg));
                        mop_next = M_K1_P01;
                    end
                    M_K1_P01:
                    begin
                        pbb_next   = sat_w(sx(pbb_reg) - sx(prod_reg));
                        state_next = ST_FIN;
                    end
                    default: state_next = ST_FIN;
                endcase
            end

            ST_CORR:
            begin
                innov_next = sat_w(sx(meas_reg) - sx(ang_reg));
                s_next     = sat_w(sx(paa_reg) + sx(rn_w));
                state_next = ST_CHK;
            end

            // skip the correction when S is not positive
            ST_CHK:
            begin
                if (s_reg[W-1] || (s_reg == '0))
                begin
                    fault_next = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    p00_next   = paa_reg;
                    p01_next   = pab_reg;
                    dn0_next   = DN'(mag(paa_reg)) << FRAC_BITS;
                    dn1_next   = DN'(mag(pba_reg)) << FRAC_BITS;
                    dneg0_next = paa_reg[W-1];
                    dneg1_next = pba_reg[W-1];
                    rem0_next  = '0;
                    rem1_next  = '0;
                    q0_next    = '0;
                    q1_next    = '0;
                    d_next     = s_reg;
                    cnt_next   = CNTW'(DN - 1);
                    state_next = ST_DIV;
                end
            end

            // restoring division, one quotient bit per lane per cycle
            ST_DIV:
            begin
                dn0_next = dn0_reg << 1;
                dn1_next = dn1_reg << 1;
                if (r20 >= {1'b0, d_reg})
                begin
                    rem0_next = W'(r20 - {1'b0, d_reg});
                    q0_next   = {q0_reg[DN-2:0], 1'b1};
                end
                else
                begin
                    rem0_next = r20[W-1:0];
                    q0_next   = {q0_reg[DN-2:0], 1'b0};
                end
                if (r21 >= {1'b0, d_reg})
                begin
                    rem1_next = W'(r21 - {1'b0, d_reg});
                    q1_next   = {q1_reg[DN-2:0], 1'b1};
                end
                else
                begin
                    rem1_next = r21[W-1:0];
                    q1_next   = {q1_reg[DN-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = ST_DFIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end

            ST_DFIN:
            begin
                k0_next    = mag_sat(dneg0_reg, SMW'(q0_reg));
                k1_next    = mag_sat(dneg1_reg, SMW'(q1_reg));
                mop_next   = M_K0_IN;
                state_next = ST_LOAD;
            end

            // hold until the output register is free
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_angle_next = ang_ext[OUT_FIELD_W-1:0];
                    out_rate_next  = rate_ext[OUT_FIELD_W-1:0];
                    out_fault_next = fault_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control, filter state, configuration and output registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mop_reg       <= M_DT_RATE;
            cnt_reg       <= '0;
            ang_reg       <= '0;
            bias_reg      <= '0;
            paa_reg       <= ONE_W;
            pab_reg       <= '0;
            pba_reg       <= '0;
            pbb_reg       <= ONE_W;
            qa_reg        <= QA_RESET;
            qb_reg        <= QB_RESET;
            rn_reg        <= RN_RESET;
            out_valid_reg <= 1'b0;
            out_angle_reg <= '0;
            out_rate_reg  <= '0;
            out_fault_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mop_reg       <= mop_next;
            cnt_reg       <= cnt_next;
            ang_reg       <= ang_next;
            bias_reg      <= bias_next;
            paa_reg       <= paa_next;
            pab_reg       <= pab_next;
            pba_reg       <= pba_next;
            pbb_reg       <= pbb_next;
            qa_reg        <= qa_next;
            qb_reg        <= qb_next;
            rn_reg        <= rn_next;
            out_valid_reg <= out_valid_next;
            out_angle_reg <= out_angle_next;
            out_rate_reg  <= out_rate_next;
            out_fault_reg <= out_fault_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        gyro_reg  <= gyro_next;
        meas_reg  <= meas_next;
        dt_reg    <= dt_next;
        rate_reg  <= rate_next;
        dp11_reg  <= dp11_next;
        innov_reg <= innov_next;
        s_reg     <= s_next;
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        p00_reg   <= p00_next;
        p01_reg   <= p01_next;
        prod_reg  <= prod_next;
        fault_reg <= fault_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        dn0_reg   <= dn0_next;
        dn1_reg   <= dn1_next;
        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
        rem0_reg  <= rem0_next;
        rem1_reg  <= rem1_next;
        d_reg     <= d_next;
        dneg0_reg <= dneg0_next;
        dneg1_reg <= dneg1_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rate_reg, out_angle_reg};
    assign m_tuser  = out_fault_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for kalman_angle_bias_filter_core (angle/bias Kalman filter).
// Depends on kabf_pkg and the core RTL; a scoreboard class predicts every result.
`default_nettype none

// Filter model: predicts angle_out, rate_out and fault for each accepted sample
class kalman_scoreboard;
    typedef struct {
        logic [31:0] angle;
        logic [31:0] rate;
        logic        fault;
    } estimate_t;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    longint    angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
    longint    qa, qb, rn;
    estimate_t awaited[$];
    int        mismatches;

    function new();
        angle_est  = 0;
        bias_est   = 0;
        cov_aa     = 64'sd16777216;
        cov_ab     = 0;
        cov_ba     = 0;
        cov_bb     = 64'sd16777216;
        qa         = kabf_pkg::QA_RESET;
        qb         = kabf_pkg::QB_RESET;
        rn         = kabf_pkg::RN_RESET;
        mismatches = 0;
    endfunction

    function longint clip(longint x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return x;
    endfunction

    // Product of two Q8.24 values, magnitude truncated, then saturated
    function longint qmul(longint a, longint b);
        longint ua, ub, q;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        q  = (ua * ub) >>> 24;
        return ((a < 0) != (b < 0)) ? clip(-q) : clip(q);
    endfunction

    // (n << 24) / d with d > 0, truncated toward zero, saturated
    function longint qdiv(longint n, longint d);
        longint un, q;
        un = (n < 0) ? -n : n;
        q  = (un <<< 24) / d;
        return (n < 0) ? clip(-q) : clip(q);
    endfunction

    function void write_reg(kabf_pkg::cfg_addr_t idx, logic [27:0] val);
        case (idx)
            kabf_pkg::CFG_ANGLE_NOISE: qa = longint'(val[24:0]);
            kabf_pkg::CFG_BIAS_NOISE:  qb = longint'(val[24:0]);
            kabf_pkg::CFG_MEAS_NOISE:  rn = longint'(val);
            default: ;
        endcase
    endfunction

    function void absorb_sample(logic [kabf_pkg::IN_TDATA_W-1:0] d);
        longint    gyro, meas, dt, rate, dp11, innov, s, k0, k1, p00, p01;
        estimate_t e;
        gyro = longint'($signed(d[31:0]));
        meas = longint'($signed(d[63:32]));
        dt   = longint'(d[84:64]);

        // predict
        rate      = clip(gyro - bias_est);
        angle_est = clip(angle_est + qmul(dt, rate));
        dp11      = qmul(dt, cov_bb);
        cov_aa    = clip(cov_aa + qmul(dt, clip(dp11 - cov_ab - cov_ba + qa)));
        cov_ab    = clip(cov_ab - dp11);
        cov_ba    = clip(cov_ba - dp11);
        cov_bb    = clip(cov_bb + qmul(qb, dt));

        // correct, unless S is not positive
        innov   = clip(meas - angle_est);
        s       = clip(cov_aa + rn);
        e.fault = (s <= 0);
        if (s > 0)
        begin
            k0        = qdiv(cov_aa, s);
            k1        = qdiv(cov_ba, s);
            angle_est = clip(angle_est + qmul(k0, innov));
            bias_est  = clip(bias_est + qmul(k1, innov));
            p00       = cov_aa;
            p01       = cov_ab;
            cov_aa    = clip(cov_aa - qmul(k0, p00));
            cov_ab    = clip(cov_ab - qmul(k0, p01));
            cov_ba    = clip(cov_ba - qmul(k1, p00));
            cov_bb    = clip(cov_bb - qmul(k1, p01));
        end
        e.angle = angle_est[31:0];
        e.rate  = rate[31:0];
        awaited.push_back(e);
    endfunction

    function void check_estimate(logic [63:0] data, logic user);
        estimate_t e;
        if (awaited.size() == 0)
        begin
            $display("%0t: result with none expected: tdata %h tuser %b", $time, data, user);
            mismatches++;
            return;
        end
        e = awaited.pop_front();
        if (data[31:0] !== e.angle)
        begin
            $display("%0t: angle_out expected %h actual %h", $time, e.angle, data[31:0]);
            mismatches++;
        end
        if (data[63:32] !== e.rate)
        begin
            $display("%0t: rate_out expected %h actual %h", $time, e.rate, data[63:32]);
            mismatches++;
        end
        if (user !== e.fault)
        begin
            $display("%0t: fault expected %b actual %b", $time, e.fault, user);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    import kabf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 200;   // wait in drain after the last result is back

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_addr_t             cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // tdata: gyro_in[31:0], accel_angle_in[63:32], step_time[84:64], zero pad
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // tdata: angle_out[31:0], rate_out[63:32]
    logic [OUT_TDATA_W-1:0] m_tdata;
    // tuser: fault[0]
    logic                  m_tuser;

    kalman_scoreboard filter_sb;
    int               cycles = 0;
    logic             steady;   // no idling on either side while set

    kalman_angle_bias_filter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sample both handshakes on the edge; values seen here are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            filter_sb.absorb_sample(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            filter_sb.check_estimate(m_tdata, m_tuser);
        m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    // Watchdog: end the run if the core stops making progress
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Write one register; the core must be idle
    task automatic write_reg(cfg_addr_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        filter_sb.write_reg(idx, val);
    endtask

    // Offer one sample and hold it until the transfer completes
    task automatic send_sample(logic [31:0] gyro, logic [31:0] accel, logic [20:0] dt);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, dt, accel, gyro};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid, then wait until every expected result is back and the core settles
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (filter_sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly plausible motion with random content, some full-range noise
    task automatic send_random();
        logic [31:0] g, a;
        logic [20:0] dt;
        if ($urandom_range(0, 99) < 70)
        begin
            g  = $urandom_range(0, 67108864) - 33554432;
            a  = $urandom_range(0, 67108864) - 33554432;
            dt = 21'($urandom_range(0, 1677722));
        end
        else
        begin
            g  = $urandom;
            a  = $urandom;
            dt = 21'($urandom);
        end
        send_sample(g, a, dt);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] qa_set[6];
        logic [CFG_DATA_W-1:0] qb_set[6];
        logic [CFG_DATA_W-1:0] rn_set[6];

        filter_sb = new();
        steady    = 1'b0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_ANGLE_NOISE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes under reset settings
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 21'd1677722);
        send_sample(32'h8000_0000, 32'h8000_0000, 21'd1677722);
        send_sample(32'h0000_0000, 32'h0000_0000, 21'd0);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001, 21'h1F_FFFF);  // step above 0.1 s
        send_sample(32'h0100_0000, 32'hFF00_0000, 21'd83886);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 21'h1F_FFFF);
        drain();

        // Zero measurement noise: gain of one collapses cov_aa, then a zero step
        // leaves S at zero and the correction is skipped
        write_reg(CFG_MEAS_NOISE, 28'd0);
        send_sample(32'h0010_0000, 32'h0080_0000, 21'd83886);
        send_sample(32'h0010_0000, 32'h0080_0000, 21'd0);
        send_sample(32'hFFF0_0000, 32'hFF80_0000, 21'd0);
        send_sample(32'h0000_0000, 32'h0000_0000, 21'd1000);
        drain();

        // Wide writes: masked upper bits, and an index beyond the list is ignored
        write_reg(CFG_ANGLE_NOISE, 28'hFFF_FFFF);
        write_reg(CFG_BIAS_NOISE, 28'hFFF_FFFF);
        write_reg(CFG_MEAS_NOISE, 28'hFFF_FFFF);
        write_reg(cfg_addr_t'(3), 28'hFFF_FFFF);
        send_sample(32'h0123_4567, 32'hFEDC_BA98, 21'd1677722);
        send_sample(32'h5555_5555, 32'hAAAA_AAAA, 21'h15_5555);
        send_sample(32'hAAAA_AAAA, 32'h5555_5555, 21'h0A_AAAA);
        drain();

        // Random phases across noise settings, extremes first
        qa_set = '{28'd16777, 28'd16777216, 28'd0, 28'd1, 28'd0, 28'd0};
        qb_set = '{28'd50332, 28'd16777216, 28'd0, 28'd1, 28'd0, 28'd0};
        rn_set = '{28'd503316, 28'd167772160, 28'd1, 28'd0, 28'd0, 28'd0};
        for (int p = 0; p < 6; p++)
        begin
            if (p >= 4)
            begin
                qa_set[p] = 28'($urandom_range(0, 16777216));
                qb_set[p] = 28'($urandom_range(0, 16777216));
                rn_set[p] = 28'($urandom_range(1, 167772160));
            end
            write_reg(CFG_ANGLE_NOISE, qa_set[p]);
            write_reg(CFG_BIAS_NOISE, qb_set[p]);
            write_reg(CFG_MEAS_NOISE, rn_set[p]);
            steady = (p == 2);
            for (int i = 0; i < 150; i++)
                send_random();
            drain();
            steady = 1'b0;
        end

        if (filter_sb.mismatches == 0 && filter_sb.awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

`default_nettype wire
